### hw/rtl/sha_pkg.sv
// SHA-256 package: round constants, initial hash values, sequencer state type
// and the round helper functions. No dependencies.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int amt);
        return (v >> amt) | (v << (32 - amt));
    endfunction

endpackage

### hw/rtl/sha256_stream_hasher.sv
// SHA-256 byte-streaming hasher: top level with block buffer, message
// schedule window, round datapath and sequencer. Depends on sha_pkg.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, op, data_byte     | into block
//  out     | out_valid, out_stall, digest_word,    | out of block
//          | word_index, last_word                 |
//
// An absorb transfer is taken only in idle; in_stall is high in other states.
// The 64th byte of a block starts a compression: the schedule window is loaded
// from the byte buffer (one word a cycle through its single read port), the
// shared round unit runs the rounds, then the chaining add. A finish writes
// padding one byte a cycle, runs one or two compressions, then presents eight
// digest words, one transfer each. The output holds under out_stall. Reset
// loads the initial hash values and clears the counters.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::state_t state_reg, state_next;

    // Byte buffer, kept as 16 words of four byte lanes.
    logic [31:0] buf_mem [0:15];
    logic [31:0] buf_rd_reg;

    logic [31:0] chain_reg [0:7];
    logic [31:0] wv_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [6:0]  cnt_reg;
    logic        finishing_reg;
    logic        final_reg;
    logic [2:0]  emit_reg;

    // Write port of the buffer and its read address.
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic [3:0]  rd_addr;

    logic in_fire, out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // Padding byte at the current fill position during finish.
    logic [7:0] pad_byte;
    always_comb
    begin
        if (!final_reg && fill_reg >= 6'd56)
        begin
            pad_byte = 8'h00;
        end
        else if (fill_reg >= 6'd56)
        begin
            pad_byte = bits_reg[8'(63 - 8 * (32'(fill_reg) - 56)) -: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    // A 0x80 byte in the last slot fills the block at once.
                    if (op == sha_pkg::OP_FINISH)
                        state_next = (fill_reg == 6'd63) ? sha_pkg::ST_LOAD
                                                         : sha_pkg::ST_PAD;
                    else if (fill_reg == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                if (fill_reg == 6'd63)
                    state_next = sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_LOAD:
            begin
                if (cnt_reg == 7'd16)
                    state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND:
            begin
                if (cnt_reg == 7'd63)
                    state_next = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD:
            begin
                if (!finishing_reg)
                    state_next = sha_pkg::ST_IDLE;
                else if (final_reg)
                    state_next = sha_pkg::ST_EMIT;
                else
                    state_next = sha_pkg::ST_PAD;
            end
            sha_pkg::ST_EMIT:
            begin
                if (out_fire && emit_reg == 3'd7)
                    state_next = sha_pkg::ST_IDLE;
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = (state_reg != sha_pkg::ST_IDLE);
        out_valid = (state_reg == sha_pkg::ST_EMIT);
        wr_en     = 1'b0;
        wr_addr   = fill_reg;
        wr_data   = data_byte;
        rd_addr   = cnt_reg[3:0];
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                wr_en   = in_fire;
                wr_data = (op == sha_pkg::OP_FINISH) ? 8'h80 : data_byte;
            end
            sha_pkg::ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_data = pad_byte;
            end
            default:
            begin
            end
        endcase
    end

    assign digest_word = chain_reg[emit_reg];
    assign word_index  = emit_reg;
    assign last_word   = (emit_reg == 3'd7);

    // Byte address 4t is the most significant lane of word t.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr[5:2]][8 * (3 - wr_addr[1:0]) +: 8] <= wr_data;
        buf_rd_reg <= buf_mem[rd_addr];
    end

    // Round unit and schedule expansion on the 16-word window.
    logic [31:0] w_new, t1, t2, s0, s1;
    always_comb
    begin
        s0 = sha_pkg::ror32(w_reg[1], 7) ^ sha_pkg::ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::ror32(w_reg[14], 17) ^ sha_pkg::ror32(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = wv_reg[7]
             + (sha_pkg::ror32(wv_reg[4], 6) ^ sha_pkg::ror32(wv_reg[4], 11)
                ^ sha_pkg::ror32(wv_reg[4], 25))
             + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
             + sha_pkg::round_k(cnt_reg[5:0]) + w_reg[0];
        t2 = (sha_pkg::ror32(wv_reg[0], 2) ^ sha_pkg::ror32(wv_reg[0], 13)
              ^ sha_pkg::ror32(wv_reg[0], 22))
             + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                ^ (wv_reg[1] & wv_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sha_pkg::ST_LOAD:
            begin
                if (cnt_reg != 7'd0)
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= buf_rd_reg;
                end
                for (int i = 0; i < 8; i++)
                    wv_reg[i] <= chain_reg[i];
            end
            sha_pkg::ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= w_new;
                wv_reg[0] <= t1 + t2;
                wv_reg[1] <= wv_reg[0];
                wv_reg[2] <= wv_reg[1];
                wv_reg[3] <= wv_reg[2];
                wv_reg[4] <= wv_reg[3] + t1;
                wv_reg[5] <= wv_reg[4];
                wv_reg[6] <= wv_reg[5];
                wv_reg[7] <= wv_reg[6];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha_pkg::ST_IDLE;
            fill_reg      <= 6'd0;
            bits_reg      <= 64'd0;
            cnt_reg       <= 7'd0;
            finishing_reg <= 1'b0;
            final_reg     <= 1'b0;
            emit_reg      <= 3'd0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha_pkg::init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    cnt_reg <= 7'd0;
                    if (in_fire)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        if (op == sha_pkg::OP_FINISH)
                        begin
                            finishing_reg <= 1'b1;
                            // Length fits in this block when the 0x80 lands at or before 55.
                            final_reg     <= (fill_reg < 6'd56);
                            if (fill_reg == 6'd63)
                                fill_reg <= 6'd0;
                        end
                        else
                            bits_reg <= bits_reg + 64'd8;
                    end
                end
                sha_pkg::ST_PAD:
                begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                        cnt_reg <= 7'd0;
                end
                sha_pkg::ST_LOAD:
                begin
                    cnt_reg <= (cnt_reg == 7'd16) ? 7'd0 : cnt_reg + 7'd1;
                end
                sha_pkg::ST_ROUND:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
                sha_pkg::ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + wv_reg[i];
                    fill_reg <= 6'd0;
                    cnt_reg  <= 7'd0;
                    if (finishing_reg)
                        final_reg <= 1'b1;
                end
                sha_pkg::ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            finishing_reg <= 1'b0;
                            final_reg     <= 1'b0;
                            bits_reg      <= 64'd0;
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= sha_pkg::init_hash(3'(i));
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_only_finishing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> finishing_reg && final_reg)
        else $error("digest shown outside a finish");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND) |-> in_stall)
        else $error("input taken during rounds");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ADD) |-> $past(cnt_reg) == 7'd63)
        else $error("compression ended early");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && last_word |=> state_reg == sha_pkg::ST_IDLE && fill_reg == 6'd0)
        else $error("state not restarted after digest");
`endif

endmodule

### sim/sha256_stream_hasher_tb.sv
// Self-checking testbench for the byte-streaming SHA-256 hasher.
// Depends on sha_pkg and sha256_stream_hasher; it predicts every digest word.
module sha256_stream_hasher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The digest words that the block is still expected to produce, oldest first.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_entry_t;

    // One message transfer waiting to be driven.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } msg_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = sha_pkg::OP_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    msg_item_t     pending_items[$];
    digest_entry_t digest_queue[$];
    int            error_count = 0;
    int            digests_seen = 0;
    int            bytes_sent = 0;
    int            items_added = 0;
    bit            quiet_phase = 1'b0;
    // Set by the monitor when the offered item was taken at the last rising edge.
    bit            in_done = 1'b0;

    // The predictor keeps its own copy of the hash state.
    logic [31:0] chain[8];
    logic [7:0]  block_buf[64];
    logic [5:0]  fill;
    logic [63:0] bit_count;

    int len_list[4] = '{55, 56, 63, 64};

    localparam logic [31:0] K_TABLE[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV_TABLE[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha256_stream_hasher i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digest_word(digest_word),
        .word_index (word_index),
        .last_word  (last_word)
    );

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of the current block buffer into the chain.
    task automatic compress_buffer();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + K_TABLE[t] + w[t];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = IV_TABLE[i];
        end
        fill = '0;
        bit_count = '0;
    endtask

    // Advances the predicted hash state by one accepted transfer and queues
    // the eight digest words that a finish produces.
    task automatic predict_transfer(input logic op_in, input logic [7:0] byte_in);
        int pos;
        digest_entry_t entry;
        if (op_in == sha_pkg::OP_ABSORB)
        begin
            block_buf[fill] = byte_in;
            fill = fill + 6'd1;
            bit_count = bit_count + 64'd8;
            if (fill == 6'd0)
            begin
                compress_buffer();
            end
        end
        else
        begin
            pos = fill;
            block_buf[pos] = 8'h80;
            pos++;
            // Padding spills into a second block when the length no longer fits.
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_buf[pos] = 8'h00;
                    pos++;
                end
                compress_buffer();
                pos = 0;
            end
            while (pos < 56)
            begin
                block_buf[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
            begin
                block_buf[56+k] = bit_count[63-8*k -: 8];
            end
            compress_buffer();
            for (int k = 0; k < 8; k++)
            begin
                entry.word = chain[k];
                entry.index = 3'(k);
                entry.last = (k == 7);
                digest_queue.push_back(entry);
            end
            restart_message();
        end
    endtask

    task automatic add_message(input int len, input bit fixed, input logic [7:0] value);
        msg_item_t item;
        for (int i = 0; i < len; i++)
        begin
            item.op = sha_pkg::OP_ABSORB;
            item.data = fixed ? value : 8'($urandom_range(0, 255));
            pending_items.push_back(item);
        end
        item.op = sha_pkg::OP_FINISH;
        item.data = 8'($urandom_range(0, 255));
        pending_items.push_back(item);
        items_added += len + 1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Driver: offers the next queued item at the falling edge and holds it
    // until a transfer happens; idles at random outside the quiet phase.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_done)
        begin
            if (pending_items.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 21))
            begin
                in_valid <= 1'b1;
                op <= pending_items[0].op;
                data_byte <= pending_items[0].data;
                void'(pending_items.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= quiet_phase ? 1'b0 : ($urandom_range(0, 99) < 21);
    end

    // Monitor: at each rising edge it feeds accepted inputs to the predictor
    // and checks every accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        digest_entry_t exp_e;
        in_done = rst_n && in_valid && !in_stall;
        if (!rst_n)
        begin
            restart_message();
        end
        if (in_done)
        begin
            predict_transfer(op, data_byte);
            if (op == sha_pkg::OP_ABSORB)
            begin
                bytes_sent++;
            end
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_queue.size() == 0)
            begin
                $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                         $time, digest_word, word_index, last_word);
                error_count++;
            end
            else
            begin
                exp_e = digest_queue.pop_front();
                if (digest_word !== exp_e.word)
                begin
                    $display("%0t: digest_word expected %h actual %h", $time, exp_e.word,
                             digest_word);
                    error_count++;
                end
                if (word_index !== exp_e.index)
                begin
                    $display("%0t: word_index expected %0d actual %0d", $time, exp_e.index,
                             word_index);
                    error_count++;
                end
                if (last_word !== exp_e.last)
                begin
                    $display("%0t: last_word expected %0b actual %0b", $time, exp_e.last,
                             last_word);
                    error_count++;
                end
                if (exp_e.last)
                begin
                    digests_seen++;
                end
            end
        end
    end

    // Stimulus: directed messages around the padding boundaries, then random
    // short lengths, with one long quiet stretch in the middle.
    initial
    begin
        int len;
        rst_n = 1'b0;
        // Empty message, single bytes at both extremes, then a random three-byte message.
        add_message(0, 1'b0, 8'h00);
        add_message(1, 1'b1, 8'h00);
        add_message(1, 1'b1, 8'hff);
        add_message(3, 1'b0, 8'h00);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_items.size() == 0 && !in_valid && digest_queue.size() == 0);
        // Lengths at the one- and two-block padding boundaries and a full block.
        foreach (len_list[i])
        begin
            add_message(len_list[i], 1'b0, 8'h00);
        end
        wait (pending_items.size() == 0 && !in_valid && digest_queue.size() == 0);
        quiet_phase = 1'b1;
        add_message(40, 1'b0, 8'h00);
        wait (pending_items.size() == 0 && !in_valid && digest_queue.size() == 0);
        quiet_phase = 1'b0;
        while (items_added < 340)
        begin
            len = $urandom_range(0, 12);
            add_message(len, 1'b0, 8'h00);
            wait (pending_items.size() < 4);
        end
        wait (pending_items.size() == 0 && !in_valid && digest_queue.size() == 0);
        repeat (200) @(posedge clk);
        $display("Covered %0d message bytes and %0d digests, padding boundaries included.",
                 bytes_sent, digests_seen);
        if (error_count == 0 && digest_queue.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Timeout with %0d digest words still outstanding.", digest_queue.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
